### src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the time sorted event queue
// Holds default sizes, field widths, action codes and the control bundle
// broadcast from the controller to every storage cell.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int TAG_BITS_DEF = 16;

    localparam int TIME_W  = 64;
    localparam int TAG_W   = 16;
    localparam int SLACK_W = 16;
    localparam int OCC_W   = 7;

    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd1000;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef struct packed {
        logic cmp_en;   // latch the per-cell threshold compare
        logic ins_en;   // open a gap and write the new entry
        logic pop_en;   // shift every entry one place toward the head
    } t_cell_ctl;

endpackage

### src/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell: one storage slot of the queue
// Holds one entry, compares it against the insert threshold and takes data
// from either neighbor when the queue opens a gap or pops the head.
// ----------------------------------------------------------------------------
module teq_cell
    import teq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int SW    = 81
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic [TIME_W-1:0] i_thr,
    input  logic [SW-1:0]    i_new,
    input  logic [SW-1:0]    i_prev,
    input  logic [SW-1:0]    i_next,
    input  logic             i_sfx_self,
    input  logic             i_sfx_prev,
    output logic [SW-1:0]    o_slot,
    output logic             o_hit
);

    logic [SW-1:0] r_slot;
    logic [SW-1:0] n_slot;
    logic          r_hit;
    logic          n_hit;
    logic          occupied;
    logic          at_pos;
    logic          past_pos;

    assign occupied = CNT_W'(IDX) < i_count;
    // Gap opens at the first slot with no qualifying entry at or behind it.
    assign at_pos   = ~i_sfx_self & i_sfx_prev;
    assign past_pos = ~i_sfx_self & ~i_sfx_prev;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.pop_en) begin
            n_slot = i_next;
        end else if (i_ctl.ins_en) begin
            if (at_pos) begin
                n_slot = i_new;
            end else if (past_pos) begin
                n_slot = i_prev;
            end
        end
    end

    assign n_hit = i_ctl.cmp_en ? (occupied & (r_slot[TIME_W-1:0] <= i_thr)) : r_hit;

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_slot = r_slot;
    assign o_hit  = r_hit;

endmodule

### src/teq_scan.sv
// ----------------------------------------------------------------------------
// teq_scan: registered suffix OR over the cell compare flags
// Bit i is set when any slot at or behind i qualifies for the threshold.
// ----------------------------------------------------------------------------
module teq_scan
    import teq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [DEPTH-1:0] i_hits,
    output logic [DEPTH-1:0] o_sfx
);

    localparam int LG = $clog2(DEPTH);

    logic [DEPTH-1:0] r_sfx;
    logic [DEPTH-1:0] n_sfx;

    // Log-step suffix OR, spreading each hit toward the head.
    always_comb begin
        n_sfx = i_hits;
        for (int j = 0; j < LG; j++) begin
            n_sfx = n_sfx | (n_sfx >> (1 << j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfx <= '0;
        end else if (i_en) begin
            r_sfx <= n_sfx;
        end
    end

    assign o_sfx = r_sfx;

endmodule

### src/time_sorted_event_queue_unit.sv
// ----------------------------------------------------------------------------
// time_sorted_event_queue_unit: ordered completion-time queue
// A pop, or an insert into a full queue, goes straight to the apply step; an insert
// steps through threshold add, per-cell compare, suffix scan and shift. busy is
// high until the result cycle, so a new item can start on the cycle the result
// strobe shows.
// Synchronous active-low reset empties the queue and loads slack_ns = 1000.
// The result is shown for one cycle on o_strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module time_sorted_event_queue_unit
    import teq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [TIME_W-1:0]  i_entry_time,
    input  logic [TAG_W-1:0]   i_entry_tag,
    input  logic               i_entry_kind,
    // configuration write channel (slack_ns)
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SLACK_W-1:0] i_cfg_data,
    // result beat
    output logic               o_strobe,
    output logic               o_out_valid,
    output logic [TIME_W-1:0]  o_out_time,
    output logic [TAG_W-1:0]   o_out_tag,
    output logic               o_out_kind,
    output logic               o_overflow,
    output logic [OCC_W-1:0]   o_occupancy
);

    // Only tag bits that survive both the port width and TAG_BITS are kept.
    localparam int TW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int SW    = TIME_W + TW + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OW    = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_CMP,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state              r_state;
    logic                r_act;
    logic [TIME_W-1:0]   r_time;
    logic [TW-1:0]       r_tag;
    logic                r_kind;
    logic [TIME_W-1:0]   r_thr;
    logic [SLACK_W-1:0]  r_slack;
    logic [CNT_W-1:0]    r_count;
    logic                r_strobe;
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_time;
    logic [TAG_W-1:0]    r_out_tag;
    logic                r_out_kind;
    logic                r_overflow;

    logic                accept;
    logic                full;
    logic                empty;
    logic [TIME_W:0]     thr_sum;
    logic [SW-1:0]       new_slot;
    logic [SW-1:0]       head;
    logic [OW-1:0]       occ_ext;
    t_cell_ctl           ctl;

    logic [SW-1:0]       slots [DEPTH];
    logic [DEPTH-1:0]    hits;
    logic [DEPTH-1:0]    sfx;

    assign accept      = start & ~busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);

    // Saturating threshold: time plus slack, clamped at the top of the range.
    assign thr_sum  = {1'b0, r_time} + {{(TIME_W + 1 - SLACK_W){1'b0}}, r_slack};
    assign new_slot = {r_kind, r_tag, r_time};
    assign head     = slots[0];

    // Broadcast control to every cell.
    always_comb begin
        ctl        = '0;
        ctl.cmp_en = (r_state == S_CMP);
        ctl.ins_en = (r_state == S_APPLY) & (r_act == ACT_INSERT) & ~full;
        ctl.pop_en = (r_state == S_APPLY) & (r_act == ACT_POP) & ~empty;
    end

    // Row of storage cells: slot 0 is the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [SW-1:0] prev_slot;
        logic [SW-1:0] next_slot;
        logic          sfx_prev;

        if (g == 0) begin : g_head
            assign prev_slot = new_slot;
            assign sfx_prev  = 1'b1;
        end else begin : g_body
            assign prev_slot = slots[g-1];
            assign sfx_prev  = sfx[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_slot = slots[g];
        end else begin : g_mid
            assign next_slot = slots[g+1];
        end

        teq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W),
            .SW    (SW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_thr      (r_thr),
            .i_new      (new_slot),
            .i_prev     (prev_slot),
            .i_next     (next_slot),
            .i_sfx_self (sfx[g]),
            .i_sfx_prev (sfx_prev),
            .o_slot     (slots[g]),
            .o_hit      (hits[g])
        );
    end

    teq_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_state == S_SCAN),
        .i_hits  (hits),
        .o_sfx   (sfx)
    );

    // Capture the command payload on accept; it holds until the next one.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_time <= i_entry_time;
            r_tag  <= i_entry_tag[TW-1:0];
            r_kind <= i_entry_kind;
        end
        if (r_state == S_THR) begin
            r_thr <= thr_sum[TIME_W] ? {TIME_W{1'b1}} : thr_sum[TIME_W-1:0];
        end
    end

    // Sequencer, occupancy and result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slack     <= SLACK_RESET;
            r_count     <= '0;
            r_strobe    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_time  <= '0;
            r_out_tag   <= '0;
            r_out_kind  <= 1'b0;
            r_overflow  <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slack <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // Pops and inserts into a full queue skip the search.
                        if (i_action == ACT_POP || full) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_state <= S_THR;
                        end
                    end
                end
                S_THR: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state     <= S_IDLE;
                    r_strobe    <= 1'b1;
                    r_out_valid <= 1'b0;
                    r_out_time  <= '0;
                    r_out_tag   <= '0;
                    r_out_kind  <= 1'b0;
                    r_overflow  <= 1'b0;
                    if (r_act == ACT_POP) begin
                        if (!empty) begin
                            r_out_valid <= 1'b1;
                            r_out_time  <= head[TIME_W-1:0];
                            r_out_tag   <= TAG_W'(head[TIME_W +: TW]);
                            r_out_kind  <= head[SW-1];
                            r_count     <= r_count - CNT_W'(1);
                        end
                    end else if (full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Occupancy reads modulo 128 when the count is wider than the port.
    assign occ_ext     = OW'(r_count);
    assign o_occupancy = occ_ext[OCC_W-1:0];
    assign o_strobe    = r_strobe;
    assign o_out_valid = r_out_valid;
    assign o_out_time  = r_out_time;
    assign o_out_tag   = r_out_tag;
    assign o_out_kind  = r_out_kind;
    assign o_overflow  = r_overflow;

endmodule

### tb/time_sorted_event_queue_unit_test.sv
// ----------------------------------------------------------------------------
// time_sorted_event_queue_unit_test: self-checking bench for the event queue
// Drives insert and pop commands through the start/busy port, keeps a shadow
// copy of the sorted queue, and compares every result beat field by field.
// Directed cases cover empty pops, head and tail placement, saturating
// thresholds, equal times and a full queue. Random traffic then runs under
// several slack settings, including both extremes.
// ----------------------------------------------------------------------------
module time_sorted_event_queue_unit_test;
    import teq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 13;

    // One result beat as the block reports it
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] etime;
        logic [TAG_W-1:0]  tag;
        logic              kind;
        logic              ovf;
        logic [OCC_W-1:0]  occ;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               i_action     = ACT_INSERT;
    logic [TIME_W-1:0]  i_entry_time = '0;
    logic [TAG_W-1:0]   i_entry_tag  = '0;
    logic               i_entry_kind = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [SLACK_W-1:0] i_cfg_data   = '0;
    logic               o_strobe;
    logic               o_out_valid;
    logic [TIME_W-1:0]  o_out_time;
    logic [TAG_W-1:0]   o_out_tag;
    logic               o_out_kind;
    logic               o_overflow;
    logic [OCC_W-1:0]   o_occupancy;

    always #5 i_clk = ~i_clk;

    time_sorted_event_queue_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_entry_time (i_entry_time),
        .i_entry_tag  (i_entry_tag),
        .i_entry_kind (i_entry_kind),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_out_valid  (o_out_valid),
        .o_out_time   (o_out_time),
        .o_out_tag    (o_out_tag),
        .o_out_kind   (o_out_kind),
        .o_overflow   (o_overflow),
        .o_occupancy  (o_occupancy)
    );

    // ------------------------------------------------------------------------
    // Shadow queue: slot 0 is the head, only slots below shadow_count are live
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]  shadow_time [DEPTH_DEF];
    logic [TAG_W-1:0]   shadow_tag  [DEPTH_DEF];
    logic               shadow_kind [DEPTH_DEF];
    int                 shadow_count = 0;
    logic [SLACK_W-1:0] shadow_slack = SLACK_RESET;

    t_outcome step_outcomes[$];    // predicted beats, oldest first
    t_outcome head_outcome;
    int       error_count  = 0;
    int       cycle_count  = 0;
    int       gap_max      = MAX_GAP;
    int       steps_sent   = 0;
    int       pops_hit     = 0;
    int       pops_empty   = 0;
    int       inserts_kept = 0;
    int       inserts_lost = 0;
    int       slack_writes = 0;

    // Apply one command to the shadow queue and return the beat it produces
    function automatic t_outcome apply_queue_step(input logic act,
                                                  input logic [TIME_W-1:0] etime,
                                                  input logic [TAG_W-1:0] tag,
                                                  input logic kind);
        t_outcome          res;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] limit;
        int                pos;
        res = '0;
        if (act == ACT_INSERT) begin
            if (shadow_count >= DEPTH_DEF) begin
                // Full: drop the entry, leave the queue untouched
                res.ovf = 1'b1;
                inserts_lost++;
            end else begin
                // Saturate the threshold at the top of the time range
                sum   = {1'b0, etime} + {{(TIME_W+1-SLACK_W){1'b0}}, shadow_slack};
                limit = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                // Place after the last stored entry at or below the threshold
                pos = 0;
                for (int i = shadow_count; i > 0; i--) begin
                    if (shadow_time[i-1] <= limit) begin
                        pos = i;
                        break;
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_time[i] = shadow_time[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                    shadow_kind[i] = shadow_kind[i-1];
                end
                shadow_time[pos] = etime;
                shadow_tag[pos]  = tag;
                shadow_kind[pos] = kind;
                shadow_count++;
                inserts_kept++;
            end
        end else if (shadow_count > 0) begin
            res.valid = 1'b1;
            res.etime = shadow_time[0];
            res.tag   = shadow_tag[0];
            res.kind  = shadow_kind[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_time[i-1] = shadow_time[i];
                shadow_tag[i-1]  = shadow_tag[i];
                shadow_kind[i-1] = shadow_kind[i];
            end
            shadow_count--;
            pops_hit++;
        end else begin
            pops_empty++;
        end
        res.occ = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: every strobe must match the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (step_outcomes.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, expected none, actual occ %0d",
                         $time, o_occupancy);
            end else begin
                head_outcome = step_outcomes.pop_front();
                check_field("out_valid", 64'(head_outcome.valid), 64'(o_out_valid));
                check_field("out_time",  64'(head_outcome.etime), 64'(o_out_time));
                check_field("out_tag",   64'(head_outcome.tag),   64'(o_out_tag));
                check_field("out_kind",  64'(head_outcome.kind),  64'(o_out_kind));
                check_field("overflow",  64'(head_outcome.ovf),   64'(o_overflow));
                check_field("occupancy", 64'(head_outcome.occ),   64'(o_occupancy));
            end
        end
    end

    // Hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one command beat. Hold start high across back-to-back beats so it
    // is never lowered and raised in the same step; drop it only for a gap.
    task automatic send_step(input logic act, input logic [TIME_W-1:0] etime,
                             input logic [TAG_W-1:0] tag, input logic kind);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_entry_time <= etime;
        i_entry_tag  <= tag;
        i_entry_kind <= kind;
        do @(posedge i_clk); while (busy);
        step_outcomes.push_back(apply_queue_step(act, etime, tag, kind));
        steps_sent++;
    endtask

    task automatic insert_entry(input logic [TIME_W-1:0] etime,
                                input logic [TAG_W-1:0] tag, input logic kind);
        send_step(ACT_INSERT, etime, tag, kind);
    endtask

    task automatic pop_head();
        send_step(ACT_POP, TIME_W'($urandom), TAG_W'($urandom), 1'($urandom));
    endtask

    // Write slack_ns only once no command is in flight and all beats are in
    task automatic set_slack(input logic [SLACK_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || step_outcomes.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_slack = value;
        slack_writes++;
    endtask

    // Mix of clustered, tiny, near-maximum and fully random times, so the
    // slack window actually decides the placement
    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(0, 3))
            0:       return TIME_W'($urandom_range(0, 5000));
            1:       return {$urandom, $urandom};
            2:       return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3000));
            default: return 64'h1_0000_0000 + TIME_W'($urandom_range(0, 200000));
        endcase
    endfunction

    task automatic random_step(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            insert_entry(random_time(), TAG_W'($urandom), 1'($urandom));
        else
            pop_head();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Default slack of 1000: empty pop, head and tail placement, slack that
    // lets a later time pass an earlier one, equal times, saturation
    task automatic test_default_slack();
        pop_head();                                    // empty dequeue
        insert_entry(64'd5000, 16'h0001, 1'b0);
        insert_entry(64'd100,  16'h0002, 1'b1);        // lands at the head
        insert_entry(64'd4500, 16'h0003, 1'b0);        // slack carries it past 5000
        insert_entry(64'd5000, 16'h0004, 1'b1);        // equal time keeps arrival order
        insert_entry({TIME_W{1'b1}}, 16'hFFFF, 1'b1);  // threshold saturates
        insert_entry({TIME_W{1'b1}} - 64'd200, 16'hAAAA, 1'b0);
        insert_entry(64'd0, 16'h5555, 1'b1);
        insert_entry(64'd0, 16'h0000, 1'b0);
        repeat (9) pop_head();                         // drain, then one empty pop
    endtask

    // Slack at both ends of its range
    task automatic test_slack_extremes();
        set_slack(16'hFFFF);
        insert_entry(64'd70000, 16'h1234, 1'b0);
        insert_entry(64'd10,    16'h4321, 1'b1);       // threshold just short: head
        insert_entry(64'd4465,  16'h0F0F, 1'b0);       // threshold equals 70000: tail
        set_slack(16'h0000);
        insert_entry(64'd7, 16'hF0F0, 1'b1);
        insert_entry(64'd7, 16'h8001, 1'b0);           // exact tie, no slack
        insert_entry(64'd6, 16'h7FFE, 1'b1);
        repeat (7) pop_head();
    endtask

    // Fill to the brim back to back, overflow, refill one slot, then drain
    task automatic test_full_queue();
        set_slack(SLACK_W'($urandom));
        gap_max = 0;
        while (shadow_count < DEPTH_DEF)
            insert_entry(random_time(), TAG_W'($urandom), 1'($urandom));
        gap_max = MAX_GAP;
        repeat (3) insert_entry(random_time(), TAG_W'($urandom), 1'($urandom));
        pop_head();
        repeat (2) insert_entry(random_time(), TAG_W'($urandom), 1'($urandom));
        repeat (DEPTH_DEF + 1) pop_head();
    endtask

    // Random traffic under several slack values; the insert share swings per
    // phase so the queue runs both near empty and into the full state
    task automatic test_random_traffic();
        logic [SLACK_W-1:0] slacks [5];
        int                 insert_pct [5];
        slacks     = '{16'h0000, 16'hFFFF, SLACK_W'($urandom), SLACK_RESET,
                       SLACK_W'($urandom)};
        insert_pct = '{80, 50, 30, 85, 50};
        for (int p = 0; p < 5; p++) begin
            set_slack(slacks[p]);
            gap_max = (p == 3) ? 0 : MAX_GAP;
            repeat (140) random_step(insert_pct[p]);
        end
        gap_max = MAX_GAP;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_slack();
        test_slack_extremes();
        test_full_queue();
        test_random_traffic();

        // Let the last beats come back, then a short tail for stray strobes
        start <= 1'b0;
        while (step_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d commands: %0d pops with an entry, %0d empty pops,",
                 steps_sent, pops_hit, pops_empty);
        $display("%0d inserts stored, %0d dropped on a full queue, %0d slack writes",
                 inserts_kept, inserts_lost, slack_writes);
        if (error_count == 0 && step_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
src/teq_pkg.sv
src/teq_cell.sv
src/teq_scan.sv
src/time_sorted_event_queue_unit.sv
tb/time_sorted_event_queue_unit_test.sv
